/* hdl/itd_pkg.sv */
`default_nettype none

package itd_pkg;

	// Widest magnitude the job format carries
	localparam int MAG_BITS = 32;

	// ASCII codes emitted
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic signed [31:0] number;
		logic [5:0]         field_width;
	} itd_item_t;

	typedef struct packed {
		logic [7:0] character;
		logic       is_last;
	} itd_char_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic [MAG_BITS-1:0] mag;
		logic                neg;
		logic [5:0]          width;
	} itd_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} itd_qstat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CONV,
		BK_SIZE,
		BK_EMIT
	} itd_bstate_t;

endpackage

`default_nettype wire

/* hdl/itd_front.sv */
`default_nettype none

module itd_front #(
	parameter int NUMBER_BITS = 32,
	parameter int MAX_WIDTH   = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire itd_pkg::itd_item_t item,
	output logic                  job_valid,
	input  wire logic             job_ready,
	output itd_pkg::itd_job_t     job
);
	import itd_pkg::*;

	localparam logic [6:0] MaxW = 7'(MAX_WIDTH);

	logic [NUMBER_BITS-1:0] raw;
	logic [NUMBER_BITS-1:0] mag;
	logic                   neg;
	logic [5:0]             wsat;
	logic                   vld_q;
	itd_job_t               job_q;

	// Split sign and magnitude, clamp the field width
	always_comb begin
		raw = item.number[NUMBER_BITS-1:0];
		neg = raw[NUMBER_BITS-1];
		mag = neg ? (~raw + 1'b1) : raw;
		if ({1'b0, item.field_width} > MaxW) begin
			wsat = MaxW[5:0];
		end else begin
			wsat = item.field_width;
		end
	end

	assign item_ready = !vld_q || job_ready;
	assign job_valid  = vld_q;
	assign job        = job_q;

	// Hold one classified beat until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (item_valid && item_ready) begin
			vld_q <= 1'b1;
		end else if (job_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			job_q.mag   <= MAG_BITS'(mag);
			job_q.neg   <= neg;
			job_q.width <= wsat;
		end
	end

endmodule

`default_nettype wire

/* hdl/itd_queue.sv */
`default_nettype none

module itd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire itd_pkg::itd_job_t push_job,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output itd_pkg::itd_job_t      pop_job,
	output itd_pkg::itd_qstat_t    stat
);
	import itd_pkg::*;

	itd_job_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

/* hdl/itd_back.sv */
`default_nettype none

module itd_back #(
	parameter int NUMBER_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              job_valid,
	output logic                   job_ready,
	input  wire itd_pkg::itd_job_t job,
	output logic                   text_valid,
	input  wire logic              text_ready,
	output itd_pkg::itd_char_t     text
);
	import itd_pkg::*;

	localparam int DIGITS   = (NUMBER_BITS * 30103) / 100000 + 1;
	localparam int BCD_BITS = 4 * DIGITS;
	localparam int IDX_W    = $clog2(DIGITS);
	localparam int BIT_W    = $clog2(NUMBER_BITS);
	localparam int CNT_W    = 7;

	itd_bstate_t            state_q, state_d;
	logic [NUMBER_BITS-1:0] sh_q;
	logic [BCD_BITS-1:0]    bcd_q;
	logic [BCD_BITS-1:0]    bcd_adj;
	logic [BIT_W-1:0]       bits_q;
	logic                   neg_q;
	logic [5:0]             width_q;
	logic [CNT_W-1:0]       total_q, pad_q, k_q;
	logic [CNT_W-1:0]       nd, text_len, total;
	logic [3:0]             dig_a [DIGITS];
	logic [IDX_W-1:0]       idx;
	logic [3:0]             digit;
	logic                   emit_fire;
	logic                   last_char;
	logic                   conv_done;
	logic                   out_vld_q;
	itd_char_t              out_q;
	itd_char_t              chr;

	// Add three to every digit of five or more before the shift
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			dig_a[d] = bcd_q[4*d +: 4];
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	// Count significant digits, at least one
	always_comb begin
		nd = CNT_W'(1);
		for (int d = 1; d < DIGITS; d++) begin
			if (bcd_q[4*d +: 4] != 4'd0) begin
				nd = CNT_W'(d + 1);
			end
		end
		text_len = nd + CNT_W'(neg_q);
		if ({1'b0, width_q} > text_len) begin
			total = {1'b0, width_q};
		end else begin
			total = text_len;
		end
	end

	// Pick the character at the current position
	always_comb begin
		idx   = IDX_W'(total_q - k_q - CNT_W'(1));
		digit = (32'(idx) < DIGITS) ? dig_a[idx] : 4'd0;
		if (k_q < pad_q) begin
			chr.character = CH_SPACE;
		end else if (neg_q && (k_q == pad_q)) begin
			chr.character = CH_MINUS;
		end else begin
			chr.character = CH_ZERO + {4'd0, digit};
		end
		chr.is_last = last_char;
	end

	assign conv_done  = (bits_q == BIT_W'(NUMBER_BITS - 1));
	assign last_char  = (k_q == total_q - CNT_W'(1));
	assign emit_fire  = (state_q == BK_EMIT) && (!out_vld_q || text_ready);
	assign text_valid = out_vld_q;
	assign text       = out_q;

	// Next state
	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		case (state_q)
			BK_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					state_d = BK_CONV;
				end
			end
			BK_CONV: begin
				if (conv_done) begin
					state_d = BK_SIZE;
				end
			end
			BK_SIZE: begin
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (emit_fire && last_char) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			bits_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_IDLE) begin
				bits_q <= '0;
			end else if (state_q == BK_CONV) begin
				bits_q <= bits_q + BIT_W'(1);
			end
			if (emit_fire) begin
				out_vld_q <= 1'b1;
			end else if (text_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Datapath: load, shift in one bit a cycle, size the field, emit
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				sh_q    <= job.mag[NUMBER_BITS-1:0];
				bcd_q   <= '0;
				neg_q   <= job.neg;
				width_q <= job.width;
			end
			BK_CONV: begin
				bcd_q <= {bcd_adj[BCD_BITS-2:0], sh_q[NUMBER_BITS-1]};
				sh_q  <= {sh_q[NUMBER_BITS-2:0], 1'b0};
			end
			BK_SIZE: begin
				total_q <= total;
				pad_q   <= total - text_len;
				k_q     <= '0;
			end
			BK_EMIT: begin
				if (emit_fire) begin
					out_q <= chr;
					k_q   <= k_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/int_to_decimal_right_justified_unit.sv */
`default_nettype none

// Channel  Signals                             Payload
// item     item_valid / item_ready / item      number, field_width
// text     text_valid / text_ready / text      character, is_last
//
// The front register and a two-entry queue take up to three items ahead of the back end.
// Each item is loaded, passes through the bit-serial BCD shifter and has its field sized,
// then leaves one character per cycle while text_ready allows: max(width, sign + digits) characters.
// Reset (arst_n low) empties the front register, the queue and the output register.
// A stalled text channel holds the back end only; the front keeps filling the queue.

module int_to_decimal_right_justified_unit #(
	parameter int MAX_WIDTH   = 32,
	parameter int NUMBER_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire itd_pkg::itd_item_t item,
	output logic                    text_valid,
	input  wire logic               text_ready,
	output itd_pkg::itd_char_t      text
);
	import itd_pkg::*;

	logic       f_valid, f_ready;
	itd_job_t   f_job;
	logic       b_valid, b_ready;
	itd_job_t   b_job;
	itd_qstat_t q_stat;

	itd_front #(
		.NUMBER_BITS(NUMBER_BITS),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	itd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_job  (f_job),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_job   (b_job),
		.stat      (q_stat)
	);

	itd_back #(
		.NUMBER_BITS(NUMBER_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job       (b_job),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text      (text)
	);

	// Queue flags never disagree
	a_qstat_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

	// Queue is never written when full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && f_ready) |-> !q_stat.full)
		else $error("queue written while full");

	// Back end pops only when the queue holds a job
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(b_valid && b_ready) |-> !q_stat.empty)
		else $error("queue read while empty");

	// Only space, minus or a decimal digit leaves the block
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |-> ((text.character == CH_SPACE) || (text.character == CH_MINUS) ||
			((text.character >= CH_ZERO) && (text.character <= CH_NINE))))
		else $error("character outside the decimal text set");

endmodule

`default_nettype wire

/* tb/itd_text_checker.sv */
`default_nettype none

module itd_text_checker #(
	parameter int MAX_WIDTH   = 32,
	parameter int NUMBER_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire logic               item_ready,
	input  wire itd_pkg::itd_item_t item,
	input  wire logic               text_valid,
	input  wire logic               text_ready,
	input  wire itd_pkg::itd_char_t text,
	output int                      failures,
	output int                      waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	import itd_pkg::*;

	// Characters still owed by the block, oldest first
	itd_char_t text_expected[$];

	// Append the right-justified decimal text of one number
	function automatic void predict_text(input itd_item_t it);
		logic [NUMBER_BITS-1:0] raw;
		logic                   neg;
		logic [NUMBER_BITS-1:0] mag;
		logic [3:0]             digs[20];
		int                     nd;
		int                     width;
		int                     text_len;
		int                     total;
		int                     pad;
		itd_char_t              ch;
		raw = it.number[NUMBER_BITS-1:0];
		neg = raw[NUMBER_BITS-1];
		mag = neg ? (~raw + 1'b1) : raw;
		width = int'(it.field_width);
		if (width > MAX_WIDTH)
			width = MAX_WIDTH;
		// Peel digits, least significant first
		nd = 0;
		do begin
			digs[nd] = 4'(mag % 10);
			mag = NUMBER_BITS'(mag / 10);
			nd++;
		end while (mag != 0);
		text_len = nd + (neg ? 1 : 0);
		total = (width > text_len) ? width : text_len;
		pad = total - text_len;
		for (int k = 0; k < total; k++) begin
			if (k < pad)
				ch.character = CH_SPACE;
			else if (neg && k == pad)
				ch.character = CH_MINUS;
			else
				ch.character = CH_ZERO + digs[nd - 1 - (k - pad - (neg ? 1 : 0))];
			ch.is_last = (k == total - 1);
			text_expected.push_back(ch);
		end
	endfunction

	initial begin
		failures = 0;
		waiting = 0;
	end

	// Compare each text beat with the oldest prediction, then record new items
	always @(posedge clk) begin
		itd_char_t want;
		if (arst_n) begin
			if (text_valid && text_ready) begin
				if (text_expected.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: unexpected text beat char %h last %b",
							$realtime, text.character, text.is_last);
				end else begin
					want = text_expected.pop_front();
					if (want.character !== text.character || want.is_last !== text.is_last) begin
						failures++;
						if (failures <= 10)
							$display("%0t: text mismatch: expected char %h last %b, got char %h last %b",
								$realtime, want.character, want.is_last,
								text.character, text.is_last);
					end
				end
			end
			if (item_valid && item_ready)
				predict_text(item);
			waiting = text_expected.size();
		end
	end

endmodule

`default_nettype wire

/* tb/int_to_decimal_right_justified_unit_tb.sv */
`default_nettype none

module int_to_decimal_right_justified_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import itd_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	itd_item_t item;
	logic      text_valid;
	logic      text_ready;
	itd_char_t text;
	int        failures;
	int        waiting;

	// Idling percentages for the current phase
	int        send_idle;
	int        recv_stall;
	bit        hold_start;

	int_to_decimal_right_justified_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text)
	);

	itd_text_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text),
		.failures   (failures),
		.waiting    (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up well past the slowest legal run
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Text receiver: random stalls, plus one long hold-off on request
	initial begin
		text_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_start) begin
				hold_start = 1'b0;
				repeat (600) begin
					text_ready <= 1'b0;
					@(posedge clk);
				end
			end
			text_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// Offer one item after an optional idle gap and hold it until accepted
	task automatic send_value(input logic signed [31:0] n, input logic [5:0] w);
		itd_item_t it;
		it.number = n;
		it.field_width = w;
		if ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
	endtask

	// Drop valid and wait until every predicted beat has arrived
	task automatic drain;
		item_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	initial begin
		int                 sel;
		int                 p;
		logic signed [31:0] n;
		logic [5:0]         w;
		arst_n = 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		send_idle = 0;
		recv_stall = 0;
		hold_start = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, widths at the edges, extremes, text wider than field
		send_value(32'sd0, 6'd0);
		send_value(32'sd0, 6'd32);
		send_value(32'sd0, 6'd63);
		send_value(32'sd1, 6'd1);
		send_value(-32'sd1, 6'd0);
		send_value(-32'sd1, 6'd2);
		send_value(-32'sd5, 6'd1);
		send_value(-32'sd42, 6'd2);
		send_value(-32'sd42, 6'd3);
		send_value(32'sd123, 6'd2);
		send_value(32'sd123, 6'd3);
		send_value(32'sd2147483647, 6'd0);
		send_value(32'sd2147483647, 6'd10);
		send_value(32'sd2147483647, 6'd11);
		send_value(32'sd2147483647, 6'd32);
		send_value(32'h8000_0000, 6'd0);
		send_value(32'h8000_0000, 6'd10);
		send_value(32'h8000_0000, 6'd11);
		send_value(32'h8000_0000, 6'd12);
		send_value(32'h8000_0000, 6'd33);
		send_value(32'h8000_0000, 6'd63);
		send_value(-32'sd1000000000, 6'd10);
		send_value(32'sd99999, 6'd40);
		send_value(32'hFFFF_FFFF, 6'd63);
		drain();

		// Random phases: no idling, sender idle, receiver stalling, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 77; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 77; end
				default: begin send_idle = 8; recv_stall = 8; end
			endcase
			if (ph == 0)
				hold_start = 1'b1;
			for (int i = 0; i < 89; i++) begin
				sel = $urandom_range(9);
				if (sel < 4) begin
					n = $urandom;
				end else if (sel < 7) begin
					n = $urandom_range(999);
					if ($urandom_range(1))
						n = -n;
				end else if (sel == 7) begin
					case ($urandom_range(3))
						0: n = 32'h8000_0000;
						1: n = 32'h7FFF_FFFF;
						2: n = 32'hFFFF_FFFF;
						default: n = 32'sd0;
					endcase
				end else begin
					// Around powers of ten, where the digit count steps
					p = 1;
					repeat ($urandom_range(9)) p *= 10;
					n = p - $urandom_range(1);
					if ($urandom_range(1))
						n = -n;
				end
				w = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12));
				send_value(n, w);
			end
			drain();
		end

		// Let any stray beat show up before the verdict
		repeat (200) @(posedge clk);
		if (failures == 0 && waiting == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
hdl/itd_pkg.sv
hdl/itd_front.sv
hdl/itd_queue.sv
hdl/itd_back.sv
hdl/int_to_decimal_right_justified_unit.sv
tb/itd_text_checker.sv
tb/int_to_decimal_right_justified_unit_tb.sv
